/* sv/bptc_pkg.sv */
// Shared constants of the barometric compensation block.
package bptc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_TEMP_CALIB  = 2'd0;
	localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
	localparam logic [1:0] REG_PRESS_MID   = 2'd2;
	localparam logic [1:0] REG_PRESS_HIGH  = 2'd3;

	// Temperature limits in Q24 degC
	localparam logic signed [31:0] T_MIN_Q24 = -32'sd671088640;   // -40 degC
	localparam logic signed [31:0] T_MAX_Q24 = 32'sd1426063360;   // 85 degC

	// Pressure limits in Q24 Pa
	localparam logic signed [63:0] C_MIN_Q24 = 64'sd503316480000;   // 30000 Pa
	localparam logic signed [63:0] C_MAX_Q24 = 64'sd2097152000000;  // 125000 Pa

	// Output range, used by the checker
	localparam logic [16:0]        PA_MIN    = 17'd30000;
	localparam logic [16:0]        PA_MAX    = 17'd125000;
	localparam logic signed [17:0] MDEG_MIN  = -18'sd40000;
	localparam logic signed [17:0] MDEG_MAX  = 18'sd85000;

endpackage

/* sv/bptc_if.sv */
// Stream interfaces for raw samples and compensated results.
interface bptc_sample_if;
	logic        valid;
	logic        ready;
	logic [23:0] pressure_sample;
	logic [23:0] temp_sample;
	modport source (output valid, pressure_sample, temp_sample, input ready);
	modport sink   (input valid, pressure_sample, temp_sample, output ready);
endinterface

interface bptc_result_if;
	logic               valid;
	logic               ready;
	logic        [16:0] pressure_pascal;
	logic signed [17:0] temp_millidegree;
	modport source (output valid, pressure_pascal, temp_millidegree, input ready);
	modport sink   (input valid, pressure_pascal, temp_millidegree, output ready);
endinterface

/* sv/baro_pressure_temp_compensate.sv */
// Barometric compensation: raw pressure/temperature in, pascal and millidegree out.
// One sample pair enters per cycle while the result side is not stalled, and its
// result passes through eight register stages; the first seven each hold one rank of
// multipliers no wider than about 32 x 32 bits (temperature quadratic, T squared,
// T cubed, the calibration products, then the three raw-pressure products of the
// cubic). Every stage has its own valid bit and loads when it is empty or when
// the stage after it moves, so bubbles are squeezed out and a stalled result
// holds the pipe without loss. Temperature is carried as Q24 degC, clamped to
// -40..85 degC; pressure is clamped to 30000..125000 Pa; both outputs are
// truncated toward zero. Calibration is written through the cfg port while idle.
module baro_pressure_temp_compensate (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [47:0]           cfg_data,
	bptc_sample_if.sink           sample,
	bptc_result_if.source         result
);

	// calibration registers
	logic [39:0] temp_calib_q;
	logic [47:0] press_low_q;
	logic [47:0] press_mid_q;
	logic [31:0] press_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q  <= '0;
			press_mid_q  <= '0;
			press_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bptc_pkg::REG_TEMP_CALIB: temp_calib_q <= cfg_data[39:0];
				bptc_pkg::REG_PRESS_LOW:  press_low_q  <= cfg_data;
				bptc_pkg::REG_PRESS_MID:  press_mid_q  <= cfg_data;
				bptc_pkg::REG_PRESS_HIGH: press_high_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// coefficient fields, all as signed values
	logic signed [16:0] t1, t2, p5, p6;
	logic signed [16:0] p1m, p2m;         // p1 - 16384, p2 - 16384
	logic signed [15:0] p9;
	logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;

	assign t1  = $signed({1'b0, temp_calib_q[15:0]});
	assign t2  = $signed({1'b0, temp_calib_q[31:16]});
	assign t3  = $signed(temp_calib_q[39:32]);
	assign p1m = $signed({press_low_q[15], press_low_q[15:0]}) - 17'sd16384;
	assign p2m = $signed({press_low_q[31], press_low_q[31:16]}) - 17'sd16384;
	assign p3  = $signed(press_low_q[39:32]);
	assign p4  = $signed(press_low_q[47:40]);
	assign p5  = $signed({1'b0, press_mid_q[15:0]});
	assign p6  = $signed({1'b0, press_mid_q[31:16]});
	assign p7  = $signed(press_mid_q[39:32]);
	assign p8  = $signed(press_mid_q[47:40]);
	assign p9  = $signed(press_high_q[15:0]);
	assign p10 = $signed(press_high_q[23:16]);
	assign p11 = $signed(press_high_q[31:24]);

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic e1, e2, e3, e4, e5, e6, e7, e8;

	assign e8 = !v_s8 || result.ready;
	assign e7 = !v_s7 || e8;
	assign e6 = !v_s6 || e7;
	assign e5 = !v_s5 || e6;
	assign e4 = !v_s4 || e5;
	assign e3 = !v_s3 || e4;
	assign e2 = !v_s2 || e3;
	assign e1 = !v_s1 || e2;

	assign sample.ready = e1;
	assign result.valid = v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else begin
			if (e1) v_s1 <= sample.valid;
			if (e2) v_s2 <= v_s1;
			if (e3) v_s3 <= v_s2;
			if (e4) v_s4 <= v_s3;
			if (e5) v_s5 <= v_s4;
			if (e6) v_s6 <= v_s5;
			if (e7) v_s7 <= v_s6;
			if (e8) v_s8 <= v_s7;
		end
	end

	// ---- stage 1: d = raw T - t1*256, d*t2, d*d
	logic signed [25:0] d;
	logic signed [24:0] ps_in;
	logic signed [42:0] dt2_s1;
	logic signed [51:0] dd_s1;
	logic signed [24:0] p_s1;

	assign d     = $signed({2'b00, sample.temp_sample}) - $signed({2'b00, t1[15:0], 8'h00});
	assign ps_in = $signed({1'b0, sample.pressure_sample});

	// ---- stage 2: T = (d*t2*2^18 + d*d*t3) / 2^24, clamped
	logic signed [63:0] tsum;
	logic signed [39:0] traw;
	logic signed [31:0] tcl;
	logic signed [31:0] t_s2;
	logic signed [24:0] p_s2;

	assign tsum = (64'(dt2_s1) <<< 18) + 64'(dd_s1) * 64'(t3);
	assign traw = tsum[63:24];
	always_comb begin
		if (traw < 40'(bptc_pkg::T_MIN_Q24))      tcl = bptc_pkg::T_MIN_Q24;
		else if (traw > 40'(bptc_pkg::T_MAX_Q24)) tcl = bptc_pkg::T_MAX_Q24;
		else                                      tcl = traw[31:0];
	end

	// ---- stage 3: T^2, millidegrees, W = p9*2^24 + p10*T
	logic signed [63:0] tt;
	logic signed [41:0] t1000;
	logic signed [41:0] t1000r;
	logic signed [37:0] tsq_s3;
	logic signed [31:0] t_s3;
	logic signed [41:0] w_s3;
	logic signed [17:0] mdeg_s3;
	logic signed [24:0] p_s3;

	assign tt     = 64'(t_s2) * 64'(t_s2);
	assign t1000  = 42'(t_s2) * 42'sd1000;
	// truncate toward zero: bias negatives before the shift
	assign t1000r = t1000 + (t1000[41] ? 42'sd16777215 : 42'sd0);

	// ---- stage 4: T^3 partials, coefficient products, P*W partials, P*P
	logic signed [46:0] tch_s4;
	logic signed [56:0] tcl_s4;
	logic signed [48:0] p6t_s4, p2t_s4;
	logic signed [45:0] p7q_s4, p3q_s4;
	logic signed [42:0] xh_s4;
	logic signed [49:0] xl_s4;
	logic signed [48:0] pp_s4;
	logic signed [17:0] mdeg_s4;
	logic signed [24:0] p_s4;

	// ---- stage 5: T^3, X = P*W/2^24, Y = P*P*p11
	logic signed [47:0] tcu_s5;
	logic signed [43:0] x_s5;
	logic signed [56:0] y_s5;
	logic signed [48:0] p6t_s5, p2t_s5;
	logic signed [45:0] p7q_s5, p3q_s5;
	logic signed [17:0] mdeg_s5;
	logic signed [24:0] p_s5;

	logic signed [63:0] tcu_w, x_w;
	assign tcu_w = 64'(tch_s4) + (64'(tcl_s4) >>> 24);
	assign x_w   = 64'(xh_s4) + (64'(xl_s4) >>> 24);

	// ---- stage 6: O1, S, P*X partials, P*Y partials
	logic signed [63:0] o1sum, ssum;
	logic signed [48:0] o1_s6;
	logic signed [50:0] s_s6;
	logic signed [44:0] o3h_s6;
	logic signed [49:0] o3l_s6;
	logic signed [57:0] o4h_s6;
	logic signed [49:0] o4l_s6;
	logic signed [17:0] mdeg_s6;
	logic signed [24:0] p_s6;

	assign o1sum = (64'($signed(p5)) <<< 42) + (64'(p6t_s5) <<< 9) + (64'(p7q_s5) <<< 7)
		+ 64'(p8) * 64'(tcu_s5);
	assign ssum  = (64'(p1m) <<< 41) + (64'(p2t_s5) <<< 8) + (64'(p3q_s5) <<< 5)
		+ 64'(p4) * 64'(tcu_s5);

	// ---- stage 7: P*S partials, O3, O4
	logic signed [51:0] o2h_s7;
	logic signed [49:0] o2l_s7;
	logic signed [48:0] o1_s7;
	logic signed [47:0] o3_s7;
	logic signed [40:0] o4_s7;
	logic signed [17:0] mdeg_s7;

	logic signed [63:0] o3_w, m_w;
	assign o3_w = 64'(o3h_s6) + (64'(o3l_s6) >>> 24);
	assign m_w  = 64'(o4h_s6) + (64'(o4l_s6) >>> 24);

	// ---- stage 8: O2, sum, clamp, whole pascals
	logic signed [63:0] c_w, c_cl;
	assign c_w = 64'(o1_s7) + 64'(o2h_s7) + (64'(o2l_s7) >>> 24) + 64'(o3_s7) + 64'(o4_s7);
	always_comb begin
		if (c_w < bptc_pkg::C_MIN_Q24)      c_cl = bptc_pkg::C_MIN_Q24;
		else if (c_w > bptc_pkg::C_MAX_Q24) c_cl = bptc_pkg::C_MAX_Q24;
		else                                c_cl = c_w;
	end

	logic        [16:0] pa_s8;
	logic signed [17:0] mdeg_s8;

	always_ff @(posedge clk) begin
		if (e1) begin
			dt2_s1 <= d * $signed(t2);
			dd_s1  <= d * d;
			p_s1   <= ps_in;
		end
		if (e2) begin
			t_s2 <= tcl;
			p_s2 <= p_s1;
		end
		if (e3) begin
			tsq_s3  <= tt[61:24];
			t_s3    <= t_s2;
			w_s3    <= (42'(p9) <<< 24) + 42'(p10) * 42'(t_s2);
			mdeg_s3 <= t1000r[41:24];
			p_s3    <= p_s2;
		end
		if (e4) begin
			tch_s4  <= t_s3 * $signed({1'b0, tsq_s3[37:24]});
			tcl_s4  <= t_s3 * $signed({1'b0, tsq_s3[23:0]});
			p6t_s4  <= p6 * t_s3;
			p2t_s4  <= p2m * t_s3;
			p7q_s4  <= p7 * tsq_s3;
			p3q_s4  <= p3 * tsq_s3;
			xh_s4   <= p_s3 * $signed(w_s3[41:24]);
			xl_s4   <= p_s3 * $signed({1'b0, w_s3[23:0]});
			pp_s4   <= p_s3 * p_s3;
			mdeg_s4 <= mdeg_s3;
			p_s4    <= p_s3;
		end
		if (e5) begin
			tcu_s5  <= tcu_w[47:0];
			x_s5    <= x_w[43:0];
			y_s5    <= pp_s4 * p11;
			p6t_s5  <= p6t_s4;
			p2t_s5  <= p2t_s4;
			p7q_s5  <= p7q_s4;
			p3q_s5  <= p3q_s4;
			mdeg_s5 <= mdeg_s4;
			p_s5    <= p_s4;
		end
		if (e6) begin
			o1_s6   <= o1sum[63:15];
			s_s6    <= ssum[63:13];
			o3h_s6  <= p_s5 * $signed(x_s5[43:24]);
			o3l_s6  <= p_s5 * $signed({1'b0, x_s5[23:0]});
			o4h_s6  <= p_s5 * $signed(y_s5[56:24]);
			o4l_s6  <= p_s5 * $signed({1'b0, y_s5[23:0]});
			mdeg_s6 <= mdeg_s5;
			p_s6    <= p_s5;
		end
		if (e7) begin
			o2h_s7  <= p_s6 * $signed(s_s6[50:24]);
			o2l_s7  <= p_s6 * $signed({1'b0, s_s6[23:0]});
			o1_s7   <= o1_s6;
			o3_s7   <= o3_w[47:0];
			o4_s7   <= m_w[57:17];
			mdeg_s7 <= mdeg_s6;
		end
		if (e8) begin
			pa_s8   <= c_cl[40:24];
			mdeg_s8 <= mdeg_s7;
		end
	end

	assign result.pressure_pascal  = pa_s8;
	assign result.temp_millidegree = mdeg_s8;

endmodule

/* sv/bptc_checker.sv */
// Port-level checks for the compensation block, bound to the top level.
module bptc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic        [16:0] pressure_pascal,
	input logic signed [17:0] temp_millidegree
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pascal)
			&& $stable(temp_millidegree))
		else $error("result changed while stalled");

	// input backs up only when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// a result taken frees the whole pipe for a new transfer
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input not ready after result transfer");

	// results stay within the clamps
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pressure_pascal >= bptc_pkg::PA_MIN
			&& pressure_pascal <= bptc_pkg::PA_MAX
			&& temp_millidegree >= bptc_pkg::MDEG_MIN
			&& temp_millidegree <= bptc_pkg::MDEG_MAX)
		else $error("result out of range");

endmodule

bind baro_pressure_temp_compensate bptc_checker u_bptc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.pressure_pascal  (result.pressure_pascal),
	.temp_millidegree (result.temp_millidegree)
);

/* dv/tb_top.sv */
// Self-checking testbench for the barometric compensation block.
module tb_top;

	localparam int WATCHDOG_LIMIT = 5000;   // cycles with no transfer on either side
	localparam int DRAIN_CYCLES   = 20;     // pipe is eight stages deep

	typedef struct {
		logic        [16:0] pascal;
		logic signed [17:0] mdeg;
	} comp_result_t;

	// Scoreboard: own copy of the calibration, fixed-point predictor and result queue
	class comp_scoreboard;
		bit [39:0]    temp_cal;
		bit [47:0]    press_lo;
		bit [47:0]    press_mid;
		bit [31:0]    press_hi;
		comp_result_t pending_results[$];
		int           mismatches;

		function void write_cal(logic [1:0] idx, logic [47:0] data);
			case (idx)
				bptc_pkg::REG_TEMP_CALIB: temp_cal  = data[39:0];
				bptc_pkg::REG_PRESS_LOW:  press_lo  = data;
				bptc_pkg::REG_PRESS_MID:  press_mid = data;
				bptc_pkg::REG_PRESS_HIGH: press_hi  = data[31:0];
				default: ;
			endcase
		endfunction

		// floor(a*v / 2^24) with the product split so it stays inside 64 bits
		function longint mul_q24(longint a, longint v);
			longint vh;
			longint vl;
			vh = v >>> 24;
			vl = v - (vh <<< 24);
			return a * vh + ((a * vl) >>> 24);
		endfunction

		function comp_result_t compensate(logic [23:0] praw, logic [23:0] traw);
			longint t1  = longint'(temp_cal[15:0]);
			longint t2  = longint'(temp_cal[31:16]);
			longint t3  = longint'($signed(temp_cal[39:32]));
			longint p1  = longint'($signed(press_lo[15:0]));
			longint p2  = longint'($signed(press_lo[31:16]));
			longint p3  = longint'($signed(press_lo[39:32]));
			longint p4  = longint'($signed(press_lo[47:40]));
			longint p5  = longint'(press_mid[15:0]);
			longint p6  = longint'(press_mid[31:16]);
			longint p7  = longint'($signed(press_mid[39:32]));
			longint p8  = longint'($signed(press_mid[47:40]));
			longint p9  = longint'($signed(press_hi[15:0]));
			longint p10 = longint'($signed(press_hi[23:16]));
			longint p11 = longint'($signed(press_hi[31:24]));
			longint p   = longint'(praw);
			longint d;
			longint tq, tsq, tcu, off1, sens, off2, wq, xq, off3, yq, off4, acc, md;
			comp_result_t r;
			d  = longint'(traw) - t1 * 256;
			tq = (d * t2 * 262144 + d * d * t3) >>> 24;
			if (tq < -40 * 64'sd16777216) tq = -40 * 64'sd16777216;
			if (tq > 85 * 64'sd16777216)  tq = 85 * 64'sd16777216;
			md = (tq * 1000) / 64'sd16777216;   // truncates toward zero
			tsq  = (tq * tq) >>> 24;
			tcu  = mul_q24(tq, tsq);
			off1 = (p5 * 64'sd4398046511104 + p6 * tq * 512 + p7 * tsq * 128 + p8 * tcu) >>> 15;
			sens = ((p1 - 16384) * 64'sd2199023255552 + (p2 - 16384) * tq * 256
				+ p3 * tsq * 32 + p4 * tcu) >>> 13;
			off2 = mul_q24(p, sens);
			wq   = p9 * 64'sd16777216 + p10 * tq;
			xq   = mul_q24(p, wq);
			off3 = mul_q24(p, xq);
			yq   = p * p * p11;
			off4 = mul_q24(p, yq) >>> 17;
			acc  = off1 + off2 + off3 + off4;
			if (acc < 30000 * 64'sd16777216)  acc = 30000 * 64'sd16777216;
			if (acc > 125000 * 64'sd16777216) acc = 125000 * 64'sd16777216;
			r.pascal = 17'(acc / 64'sd16777216);
			r.mdeg   = md[17:0];
			return r;
		endfunction

		function void note_sample(logic [23:0] praw, logic [23:0] traw);
			pending_results.push_back(compensate(praw, traw));
		endfunction

		function void check_result(logic [16:0] pa, logic signed [17:0] md);
			comp_result_t exp_r;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result pa=%0d mdeg=%0d", pa, md);
				return;
			end
			exp_r = pending_results.pop_front();
			if (pa !== exp_r.pascal || md !== exp_r.mdeg) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: pa exp %0d got %0d, mdeg exp %0d got %0d",
						exp_r.pascal, pa, exp_r.mdeg, md);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = bptc_pkg::REG_TEMP_CALIB;
	logic [47:0] cfg_data = '0;

	bptc_sample_if sample ();
	bptc_result_if result ();

	comp_scoreboard comp_sb = new();
	int send_idle_pct;   // sender gap chance, per cent
	int recv_stall_pct;  // receiver stall chance, per cent
	int quiet_cycles;

	baro_pressure_temp_compensate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample.sink),
		.result    (result.source)
	);

	always #10 clk = ~clk;

	initial begin
		sample.valid           = 1'b0;
		sample.pressure_sample = '0;
		sample.temp_sample     = '0;
		result.ready           = 1'b0;
	end

	// Receiver: ready toggles at random per the current stall rate
	always @(posedge clk)
		result.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	// Inputs only move at the rising edge, so values seen at the falling edge
	// are those the next rising edge samples: checking and watchdog live here.
	always @(negedge clk) begin
		if (result.valid && result.ready)
			comp_sb.check_result(result.pressure_pascal, result.temp_millidegree);
		if ((result.valid && result.ready) || (sample.valid && sample.ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Four calibration writes back to back; we drops once at the end
	task automatic load_calibration(logic [39:0] tc, logic [47:0] lo, logic [47:0] mid,
			logic [31:0] hi);
		logic [47:0] vals [4];
		vals[0] = {8'h00, tc};
		vals[1] = lo;
		vals[2] = mid;
		vals[3] = {16'h0000, hi};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data  <= vals[i];
			comp_sb.write_cal(i[1:0], vals[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// One sample transfer, with random gaps ahead of it
	task automatic send_sample(logic [23:0] praw, logic [23:0] traw);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid           <= 1'b1;
		sample.pressure_sample <= praw;
		sample.temp_sample     <= traw;
		do begin
			@(negedge clk);
			taken = sample.ready;
			@(posedge clk);
		end while (!taken);
		comp_sb.note_sample(praw, traw);
	endtask

	task automatic wait_drained();
		sample.valid <= 1'b0;
		while (comp_sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random pair: mostly temperatures near the calibrated zero point, some anywhere
	task automatic send_random(int n);
		logic [23:0] t_centre;
		logic [23:0] traw;
		for (int i = 0; i < n; i++) begin
			t_centre = {comp_sb.temp_cal[15:0], 8'h00};
			if ($urandom_range(3) == 0)
				traw = 24'($urandom());
			else
				traw = t_centre + 24'($signed($urandom_range(400000)) - 200000);
			send_sample(24'($urandom()), traw);
			if (i == n / 2 && $urandom_range(1) == 0)
				wait_drained();   // sender holds off until the pipe has emptied
		end
	endtask

	initial begin
		logic [23:0] corner_p [4];
		logic [23:0] corner_t [4];
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration (all zero) is a valid set of coefficients
		send_sample(24'h000000, 24'h000000);
		send_sample(24'hFFFFFF, 24'hFFFFFF);
		send_sample(24'h800000, 24'h7FFFFF);
		wait_drained();

		// Typical calibration, directed corners: clamps at both ends of each output
		load_calibration({8'hF9, 16'd19000, 16'd27000},
			{8'hFF, 8'hF6, 16'hFFF0, 16'hFC00},
			{8'hF0, 8'h0F, 16'd33000, 16'd22000},
			{8'hE5, 8'h04, 16'd9000});
		corner_p = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h6E0000};
		corner_t = '{24'h000000, 24'hFFFFFF, 24'h697800, 24'h700000};
		foreach (corner_p[i])
			foreach (corner_t[j])
				send_sample(corner_p[i], corner_t[j]);
		send_random(330);
		wait_drained();

		// Sender gaps, all-ones calibration (every bit of every field set)
		send_idle_pct = 61;
		load_calibration('1, '1, '1, '1);
		send_sample(24'hFFFFFF, 24'h000000);
		send_sample(24'h000000, 24'hFFFFFF);
		send_random(340);
		wait_drained();

		// Receiver stalls, random calibration
		send_idle_pct  = 0;
		recv_stall_pct = 61;
		load_calibration(40'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
			48'({$urandom(), $urandom()}), $urandom());
		send_random(340);
		wait_drained();

		// Both sides idle now and then; back to typical calibration with random trims
		send_idle_pct  = 10;
		recv_stall_pct = 10;
		load_calibration({8'($urandom_range(255)), 16'($urandom_range(15000, 25000)),
				16'($urandom_range(24000, 30000))},
			{8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom())},
			{8'($urandom()), 8'($urandom()), 16'($urandom()), 16'($urandom())},
			$urandom());
		send_random(360);
		wait_drained();

		if (comp_sb.mismatches == 0 && comp_sb.pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
